// ===== rtl/core/ccpio_pkg.sv =====
// ----------------------------------------------------------------------------
// ccpio_pkg - shared types and constants
// op codes, register offsets, status codes, protection keys and config values
// ----------------------------------------------------------------------------
`default_nettype none

package ccpio_pkg;

  // op codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // register offsets in the window
  localparam logic [3:0] ADDR_CCP    = 4'h4;
  localparam logic [3:0] ADDR_RAMPD  = 4'h8;
  localparam logic [3:0] ADDR_RAMPX  = 4'h9;
  localparam logic [3:0] ADDR_RAMPY  = 4'hA;
  localparam logic [3:0] ADDR_RAMPZ  = 4'hB;
  localparam logic [3:0] ADDR_EIND   = 4'hC;
  localparam logic [3:0] ADDR_SPL    = 4'hD;
  localparam logic [3:0] ADDR_SPH    = 4'hE;
  localparam logic [3:0] ADDR_SREG   = 4'hF;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RD_RSVD  = 2'd1;
  localparam logic [1:0] ST_WR_RSVD  = 2'd2;

  // protection keys and window length
  localparam logic [7:0] KEY_IOREG     = 8'hD8;
  localparam logic [7:0] KEY_SPM       = 8'h9D;
  localparam logic [2:0] PROTECT_TICKS = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_EXT_MASK  = 2'd0;
  localparam logic [1:0] CFG_JUMP_MASK = 2'd1;
  localparam logic [1:0] CFG_SP_RESET  = 2'd2;

  localparam logic [7:0]  EXT_MASK_RST = 8'hFF;
  localparam logic [7:0]  JMP_MASK_RST = 8'hFF;
  localparam logic [15:0] SP_RESET_RST = 16'h1FFF;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] addr;
    logic [7:0] wdata;
  } req_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic [1:0] status;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/ccpio_regs.sv =====
// ----------------------------------------------------------------------------
// ccpio_regs - register window state
// decodes one request beat, updates state and forms its result
// ----------------------------------------------------------------------------
`default_nettype none

module ccpio_regs (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_data,
  input  wire logic              req_fire,
  input  wire ccpio_pkg::req_t   req,
  output ccpio_pkg::result_t     res
);
  import ccpio_pkg::*;

  logic [7:0]  ext_addr_mask;
  logic [7:0]  jump_ext_mask;
  logic [7:0]  key_latch;
  logic [2:0]  ioreg_protect_count;
  logic [2:0]  spm_protect_count;
  logic [7:0]  ext_addr_regs [4];
  logic [7:0]  jump_ext;
  logic [15:0] stack_pointer;
  logic [7:0]  status_flags;

  logic        is_ext;
  logic        is_valid_addr;

  assign is_ext = (req.addr[3:2] == ADDR_RAMPD[3:2]);
  assign is_valid_addr = (req.addr == ADDR_CCP) || req.addr[3];

  // read data and status
  always_comb begin
    res.rdata  = 8'd0;
    res.status = ST_OK;
    if (req.op == OP_READ) begin
      if (!is_valid_addr) begin
        res.status = ST_RD_RSVD;
      end else if (req.addr == ADDR_CCP) begin
        res.rdata = {6'd0, (spm_protect_count != 3'd0), (ioreg_protect_count != 3'd0)};
      end else if (is_ext) begin
        res.rdata = ext_addr_regs[req.addr[1:0]];
      end else if (req.addr == ADDR_EIND) begin
        res.rdata = jump_ext;
      end else if (req.addr == ADDR_SPL) begin
        res.rdata = stack_pointer[7:0];
      end else if (req.addr == ADDR_SPH) begin
        res.rdata = stack_pointer[15:8];
      end else begin
        res.rdata = status_flags;
      end
    end else if (req.op == OP_WRITE && !is_valid_addr) begin
      res.status = ST_WR_RSVD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_addr_mask       <= EXT_MASK_RST;
      jump_ext_mask       <= JMP_MASK_RST;
      key_latch           <= 8'd0;
      ioreg_protect_count <= 3'd0;
      spm_protect_count   <= 3'd0;
      for (int i = 0; i < 4; i++) ext_addr_regs[i] <= 8'd0;
      jump_ext            <= 8'd0;
      stack_pointer       <= SP_RESET_RST;
      status_flags        <= 8'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_EXT_MASK:  ext_addr_mask <= cfg_data[7:0];
          CFG_JUMP_MASK: jump_ext_mask <= cfg_data[7:0];
          CFG_SP_RESET: begin
            // the strap value loads the stack pointer at once
            stack_pointer <= cfg_data;
          end
          default: ;
        endcase
      end
      if (req_fire) begin
        if (req.op == OP_WRITE) begin
          if (req.addr == ADDR_CCP) begin
            key_latch <= req.wdata;
          end else if (is_ext) begin
            ext_addr_regs[req.addr[1:0]] <= req.wdata & ext_addr_mask;
          end else if (req.addr == ADDR_EIND) begin
            jump_ext <= req.wdata & jump_ext_mask;
          end else if (req.addr == ADDR_SPL) begin
            stack_pointer[7:0] <= req.wdata;
          end else if (req.addr == ADDR_SPH) begin
            stack_pointer[15:8] <= req.wdata;
          end else if (req.addr == ADDR_SREG) begin
            status_flags <= req.wdata;
          end
        end else if (req.op == OP_TICK) begin
          // a latched key re-arms its window; otherwise a running count steps down
          if (key_latch == KEY_IOREG) begin
            ioreg_protect_count <= PROTECT_TICKS;
            key_latch           <= 8'd0;
          end else if (ioreg_protect_count != 3'd0) begin
            ioreg_protect_count <= ioreg_protect_count - 3'd1;
          end
          if (key_latch == KEY_SPM) begin
            spm_protect_count <= PROTECT_TICKS;
            key_latch         <= 8'd0;
          end else if (spm_protect_count != 3'd0) begin
            spm_protect_count <= spm_protect_count - 3'd1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ccpio_out.sv =====
// ----------------------------------------------------------------------------
// ccpio_out - result register
// holds one result beat and frees itself as the beat leaves
// ----------------------------------------------------------------------------
`default_nettype none

module ccpio_out (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire ccpio_pkg::result_t res,
  output logic                    can_load,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              rdata,
  output logic [1:0]              status
);
  import ccpio_pkg::*;

  result_t held;

  assign can_load = !out_valid || out_ready;
  assign rdata    = held.rdata;
  assign status   = held.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cpu_io_registers_with_ccp.sv =====
// ----------------------------------------------------------------------------
// cpu_io_registers_with_ccp - cpu i/o register window with change protection
// extended address, jump extension, stack pointer, status and ccp registers
// ----------------------------------------------------------------------------
//
//   channel | direction | signals                       | beat
//   --------+-----------+-------------------------------+-------------------
//   in      | to block  | in_valid in_ready op addr wdata | read, write, tick
//   out     | from block| out_valid out_ready rdata status| one per in beat
//   cfg     | to block  | cfg_we cfg_index cfg_data       | no handshake
//
// one beat per cycle sustained while out_ready stays high; a result appears the cycle after its beat
// is taken, set by the single result register after the decode logic
// in_ready drops only while a result is held and out_ready is low
// synchronous active-high reset; stack pointer comes up at SP_RESET_RST,
// everything else at zero, masks at all ones
// ----------------------------------------------------------------------------
`default_nettype none

module cpu_io_registers_with_ccp (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration writes
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [3:0]  addr,
  input  wire logic [7:0]  wdata,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       rdata,
  output logic [1:0]       status
);
  import ccpio_pkg::*;

  req_t    req;
  result_t res;
  logic    fire;

  assign req  = '{op: op, addr: addr, wdata: wdata};
  // a beat is taken when the result register is free or draining
  assign fire = in_valid && in_ready;

  // state update and result decode in the same cycle
  ccpio_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_fire  (fire),
    .req       (req),
    .res       (res)
  );

  // result register parts the two sides
  ccpio_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res       (res),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rdata     (rdata),
    .status    (status)
  );

endmodule

`default_nettype wire
